FILE: rtl/voltage_vector_limit_sqrt_assert.svh
// ----------------------------------------------------------------------------
// voltage_vector_limit_sqrt assertion macros
// Shared concurrent assertion forms for the voltage vector limit block.
// ----------------------------------------------------------------------------
`ifndef VOLTAGE_VECTOR_LIMIT_SQRT_ASSERT_SVH
`define VOLTAGE_VECTOR_LIMIT_SQRT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define VVLS_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define VVLS_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/vvls_pkg.sv
// ----------------------------------------------------------------------------
// vvls_pkg
// Widths, constants and request types for the voltage vector limit block.
// ----------------------------------------------------------------------------
package vvls_pkg;

  // field widths
  localparam int MAG_W  = 17;          // magnitude of a 17-bit signed index
  localparam int SQ_W   = 2 * MAG_W;   // exact square
  localparam int RAD_W  = 32;          // radicand
  localparam int EST_W  = 32;          // Newton estimate
  localparam int ROOT_W = 16;
  localparam int MOD_W  = 16;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register map, index taken from the word address
  localparam logic REG_MAX_MOD = 1'b0;
  localparam logic [MOD_W-1:0] MOD_RESET = 16'd37837;  // 2/sqrt(3) in Q15

  // starting guess thresholds and shifts
  localparam logic [RAD_W-1:0] THR_LO  = 32'd10000;
  localparam logic [RAD_W-1:0] THR_MID = 32'd10000000;
  localparam logic [RAD_W-1:0] THR_HI  = 32'd1000000000;
  localparam logic [4:0] SH_LO  = 5'd5;
  localparam logic [4:0] SH_MID = 5'd9;
  localparam logic [4:0] SH_HI  = 5'd13;
  localparam logic [4:0] SH_TOP = 5'd15;

  // Newton step bound
  localparam int NEWTON_CAP = 64;
  localparam int STEP_W     = $clog2(NEWTON_CAP);

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            done;
    logic [SQ_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] num;
    logic [EST_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RAD_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: rtl/vvls_sqmul.sv
// ----------------------------------------------------------------------------
// vvls_sqmul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module vvls_sqmul (
  input  logic              clk,
  input  logic              rst_n,
  input  vvls_pkg::mul_req_t req,
  output vvls_pkg::mul_rsp_t rsp
);
  import vvls_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MAG_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] a_r, a_nxt;
  // upper part (MAG_W+1) accumulates, lower part shifts the multiplier out
  logic [2*MAG_W:0] p_r, p_nxt;
  logic [MAG_W:0]   hi_sum;

  // one add per cycle on the upper half
  always_comb begin
    hi_sum   = p_r[2*MAG_W:MAG_W] + (p_r[0] ? {1'b0, a_r} : {(MAG_W+1){1'b0}});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    p_nxt    = p_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = req.a;
      p_nxt    = {{(MAG_W+1){1'b0}}, req.b};
    end else if (busy_r) begin
      p_nxt   = {1'b0, hi_sum, p_r[MAG_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    p_r <= p_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = p_r[SQ_W-1:0];

endmodule

FILE: rtl/vvls_div.sv
// ----------------------------------------------------------------------------
// vvls_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vvls_div (
  input  logic              clk,
  input  logic              rst_n,
  input  vvls_pkg::div_req_t req,
  output vvls_pkg::div_rsp_t rsp
);
  import vvls_pkg::*;

  localparam int CNT_W = $clog2(RAD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(RAD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [EST_W-1:0] den_r, den_nxt;
  logic [EST_W-1:0] rem_r, rem_nxt;
  logic [RAD_W-1:0] quo_r, quo_nxt;   // dividend shifts out, quotient in
  logic [EST_W:0]   trial;
  logic [EST_W+1:0] diff;
  logic             fits;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial    = {rem_r, quo_r[RAD_W-1]};
    diff     = {1'b0, trial} - {2'b00, den_r};
    fits     = !diff[EST_W+1];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = req.den;
      rem_nxt  = '0;
      quo_nxt  = req.num;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[EST_W-1:0] : trial[EST_W-1:0];
      quo_nxt = {quo_r[RAD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

FILE: rtl/voltage_vector_limit_sqrt.sv
// ----------------------------------------------------------------------------
// voltage_vector_limit_sqrt
// Voltage vector magnitude or q-axis headroom by integer Newton square root.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per item. in_tdata holds ud and uq (Q15, signed),
//           in_tuser[0] is the action: 0 = sqrt(ud^2+uq^2),
//           1 = sqrt(max^2-ud^2). A request is taken when in_tvalid and
//           in_tready are both high; in_tready is high while no item is in
//           flight.
//   out_* : one result per request. out_tdata is the root, out_tuser[0] the
//           clamp flag (headroom overdrawn, root forced to 0).
//   cfg_* : APB register port, max_modulation at address 0, pready always 1.
// Sequence: two serial squarings, a setup step, then Newton steps, each
//   an issue, a bit-serial divide and an update.
//   A clamped item skips the setup and the iteration.
// Throughput: one item at a time; the divider loop sets the rate.
// Reset: max_modulation returns to 37837, the pipeline empties.
// Stall: a result waits in the output register; a new request is taken
//   meanwhile, and its finished result waits until the register is free.
// ----------------------------------------------------------------------------
`include "voltage_vector_limit_sqrt_assert.svh"

module voltage_vector_limit_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [39:0]                 in_tdata,   // [16:0] ud, [33:17] uq, [39:34] zero
  input  logic [0:0]                  in_tuser,   // [0] action
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [vvls_pkg::ROOT_W-1:0] out_tdata,  // [15:0] root
  output logic [0:0]                  out_tuser,  // [0] clamped
  // register port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [vvls_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [vvls_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [vvls_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import vvls_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL_A = 3'd1;
  localparam logic [2:0] S_MUL_B = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_ISSUE = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NEWTON_CAP - 1);
  localparam logic [EST_W-1:0]  ROOT_MAX  = EST_W'({ROOT_W{1'b1}});

  logic [2:0]        state_r, state_nxt;
  logic [MOD_W-1:0]  max_r;
  logic              action_r, action_nxt;
  logic [MAG_W-1:0]  opb_r, opb_nxt;
  logic [SQ_W-1:0]   ud2_r, ud2_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [EST_W-1:0]  est_r, est_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              clamp_r, clamp_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0] out_root_r, out_root_nxt;
  logic              out_clamp_r, out_clamp_nxt;

  logic              in_acc;
  logic              cfg_wr;
  logic [MAG_W-1:0]  ud_mag, uq_mag;
  logic [SQ_W:0]     sum_sq;
  logic [4:0]        sh;
  logic [EST_W:0]    newt_sum;
  logic [EST_W-1:0]  est_new;
  logic [EST_W-1:0]  drop;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // magnitude of a signed Q15 index; -65536 maps to 65536
  function automatic logic [MAG_W-1:0] mag17(input logic [MAG_W-1:0] v);
    mag17 = v[MAG_W-1] ? (~v + 1'b1) : v;
  endfunction

  assign in_acc = in_tvalid && in_tready;
  assign ud_mag = mag17(in_tdata[MAG_W-1:0]);
  assign uq_mag = mag17(in_tdata[2*MAG_W-1:MAG_W]);

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_MOD) ?
                      {{(DATA_W-MOD_W){1'b0}}, max_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MOD_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_MAX_MOD)) begin
      max_r <= cfg_pwdata[MOD_W-1:0];
    end
  end

  // serial units
  vvls_sqmul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  vvls_div   u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = ud_mag;
    mul_req.b     = ud_mag;
    if (state_r == S_IDLE) begin
      mul_req.start = in_acc;
    end else if (state_r == S_MUL_A) begin
      mul_req.start = mul_rsp.done;
      mul_req.a     = opb_r;
      mul_req.b     = opb_r;
    end
  end

  assign div_req.start = (state_r == S_ISSUE) && (est_r != '0);
  assign div_req.num   = rad_r;
  assign div_req.den   = est_r;

  // starting guess shift by threshold
  always_comb begin
    if (rad_r < THR_LO) begin
      sh = SH_LO;
    end else if (rad_r < THR_MID) begin
      sh = SH_MID;
    end else if (rad_r < THR_HI) begin
      sh = SH_HI;
    end else begin
      sh = SH_TOP;
    end
  end

  // Newton update and drop against the previous estimate
  assign sum_sq   = {1'b0, ud2_r} + {1'b0, mul_rsp.prod};
  assign newt_sum = {1'b0, est_r} + {1'b0, div_rsp.quo};
  assign est_new  = newt_sum[EST_W:1];
  assign drop     = est_r - est_new;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    opb_nxt       = opb_r;
    ud2_nxt       = ud2_r;
    rad_nxt       = rad_r;
    est_nxt       = est_r;
    step_nxt      = step_r;
    clamp_nxt     = clamp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_root_nxt  = out_root_r;
    out_clamp_nxt = out_clamp_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          action_nxt = in_tuser[0];
          opb_nxt    = in_tuser[0] ? {{(MAG_W-MOD_W){1'b0}}, max_r} : uq_mag;
          clamp_nxt  = 1'b0;
          state_nxt  = S_MUL_A;
        end
      end
      S_MUL_A: begin
        if (mul_rsp.done) begin
          ud2_nxt   = mul_rsp.prod;
          state_nxt = S_MUL_B;
        end
      end
      S_MUL_B: begin
        if (mul_rsp.done) begin
          state_nxt = S_PREP;
          if (!action_r) begin
            // sum saturates to the 32-bit radicand
            rad_nxt = (sum_sq[SQ_W:RAD_W] != '0) ? {RAD_W{1'b1}} : sum_sq[RAD_W-1:0];
          end else if (ud2_r > mul_rsp.prod) begin
            // headroom overdrawn
            clamp_nxt = 1'b1;
            est_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            rad_nxt = RAD_W'(mul_rsp.prod - ud2_r);
          end
        end
      end
      S_PREP: begin
        est_nxt   = (rad_r >> sh) + 1'b1;
        step_nxt  = '0;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        state_nxt = (est_r == '0) ? S_FIN : S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          est_nxt  = est_new;
          step_nxt = step_r + 1'b1;
          if (drop <= EST_W'(1) || step_r == STEP_LAST) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = (est_r > ROOT_MAX) ? {ROOT_W{1'b1}} : est_r[ROOT_W-1:0];
          out_clamp_nxt = clamp_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      clamp_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      clamp_r     <= clamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r    <= action_nxt;
    opb_r       <= opb_nxt;
    ud2_r       <= ud2_nxt;
    rad_r       <= rad_nxt;
    est_r       <= est_nxt;
    out_root_r  <= out_root_nxt;
    out_clamp_r <= out_clamp_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_root_r;
  assign out_tuser  = out_clamp_r;

  // checks
  `VVLS_ASSERT_IMP(a_clamp_zero, clk, rst_n, out_tvalid && out_tuser[0],
                   out_tdata == '0, "clamped result with nonzero root")
  `VVLS_ASSERT_IMP(a_div_nonzero, clk, rst_n, div_req.start, div_req.den != '0,
                   "divider started with zero divisor")
  `VVLS_ASSERT_IMP(a_mul_done_state, clk, rst_n, mul_rsp.done,
                   state_r == S_MUL_A || state_r == S_MUL_B,
                   "multiplier finished outside a squaring state")
  `VVLS_ASSERT_NXT(a_busy_after_acc, clk, rst_n, in_acc, !in_tready,
                   "request taken while previous item still in flight")

endmodule

FILE: sim/tb_voltage_vector_limit_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voltage_vector_limit_sqrt
// Self-checking bench for the voltage vector magnitude / q headroom root.
// Each accepted request is run through a local Newton square root predictor.
// Results are matched in order. The max_modulation register is swept
// through several values between phases. Both stream sides idle at random,
// and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_voltage_vector_limit_sqrt;
  import vvls_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = 400;
  localparam int LONG_HOLD   = 1500;
  localparam int MAX_IDLE    = 8;

  // register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_MAX_MOD = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_SPARE   = 3'd4;

  typedef enum logic {
    ACT_MAGNITUDE = 1'b0,
    ACT_HEADROOM  = 1'b1
  } action_t;

  typedef struct packed {
    action_t                 action;
    logic signed [MAG_W-1:0] ud;
    logic signed [MAG_W-1:0] uq;
  } vec_req_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              clamped;
  } root_result_t;

  // --------------------------------------------------------------------------
  // expected-root store and predictor
  // --------------------------------------------------------------------------
  class root_scoreboard;
    logic [MOD_W-1:0] max_mod = MOD_RESET;
    root_result_t     expected_roots[$];
    int               mismatches = 0;

    // Newton root, start guess shifted by radicand threshold
    function automatic logic [31:0] newton_isqrt(logic [31:0] rad);
      logic [31:0] est;
      logic [31:0] prev;
      logic [31:0] drop;
      logic [32:0] sum;
      logic [4:0]  sh;
      if (rad < THR_LO)       sh = SH_LO;
      else if (rad < THR_MID) sh = SH_MID;
      else if (rad < THR_HI)  sh = SH_HI;
      else                    sh = SH_TOP;
      est = (rad >> sh) + 32'd1;
      for (int n = 0; n < NEWTON_CAP; n++) begin
        prev = est;
        if (est == 32'd0) break;
        sum  = {1'b0, est} + {1'b0, rad / est};
        est  = sum[32:1];
        drop = prev - est;   // a rise wraps to a large drop
        if (drop <= 32'd1) break;
      end
      return est;
    endfunction

    function automatic root_result_t predict_root(vec_req_t r);
      longint       d;
      longint       q;
      longint       m;
      longint       rad;
      logic [31:0]  est;
      root_result_t res;
      d = r.ud;
      q = r.uq;
      m = max_mod;
      res.clamped = 1'b0;
      if (r.action == ACT_MAGNITUDE) begin
        rad = d * d + q * q;
        if (rad > 64'hFFFF_FFFF) rad = 64'hFFFF_FFFF;
        est = newton_isqrt(rad[31:0]);
      end else if (d * d > m * m) begin
        est = 32'd0;
        res.clamped = 1'b1;
      end else begin
        rad = m * m - d * d;
        est = newton_isqrt(rad[31:0]);
      end
      res.root = (est > 32'hFFFF) ? 16'hFFFF : est[ROOT_W-1:0];
      return res;
    endfunction

    function void note_request(vec_req_t r);
      expected_roots.push_back(predict_root(r));
    endfunction

    function void check_root(root_result_t got);
      root_result_t exp_res;
      if (expected_roots.size() == 0) begin
        $error("unexpected result: root %0d clamped %0d", got.root, got.clamped);
        mismatches++;
        return;
      end
      exp_res = expected_roots.pop_front();
      if (got.root !== exp_res.root) begin
        $error("root: expected %0d, actual %0d", exp_res.root, got.root);
        mismatches++;
      end
      if (got.clamped !== exp_res.clamped) begin
        $error("clamped: expected %0d, actual %0d", exp_res.clamped, got.clamped);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, block
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata    = '0;   // [16:0] ud, [33:17] uq, [39:34] zero
  logic [0:0]        in_tuser    = '0;   // [0] action
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [ROOT_W-1:0] out_tdata;          // [15:0] root
  logic [0:0]        out_tuser;          // [0] clamped
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  voltage_vector_limit_sqrt dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  root_scoreboard sb = new();
  bit             idle_on      = 1'b1;
  int             results_seen = 0;
  int             cycle_count  = 0;

  // --------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    vec_req_t r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        r.action = action_t'(in_tuser[0]);
        r.ud     = in_tdata[16:0];
        r.uq     = in_tdata[33:17];
        sb.note_request(r);
      end
      if (out_tvalid && out_tready) begin
        sb.check_root('{root: out_tdata, clamped: out_tuser[0]});
        results_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stalls, one long hold-off to back up the block
  // --------------------------------------------------------------------------
  initial begin
    int  stall;
    bit  long_hold_done;
    long_hold_done = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (!long_hold_done && results_seen >= 60) begin
        stall = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // one request, optional gap first; returns right after the accepting edge
  task automatic send_request(input vec_req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, r.uq, r.ud};
    in_tuser  <= r.action;
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid, then wait for every outstanding result
  task automatic drain_requests();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_roots.size() != 0) @(posedge clk);
  endtask

  // APB access; a read is checked against the modeled register
  task automatic apb_access(input bit write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (write) begin
      if ((addr >> 2) == REG_MAX_MOD) sb.max_mod = data[MOD_W-1:0];
    end else if (cfg_prdata !== {{(DATA_W-MOD_W){1'b0}}, sb.max_mod}) begin
      $error("max_modulation: expected %0d, actual %0d", sb.max_mod, cfg_prdata);
      sb.mismatches++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic vec_req_t make_req(action_t a, int d, int q);
    vec_req_t r;
    r.action = a;
    r.ud     = d[MAG_W-1:0];
    r.uq     = q[MAG_W-1:0];
    return r;
  endfunction

  // mostly in-range vectors, plus full-width, small and near-budget values
  function automatic vec_req_t random_request();
    int d;
    int q;
    int sel;
    sel = $urandom_range(0, 9);
    q   = int'($urandom_range(0, 92680)) - 46340;
    case (sel)
      0: begin
        d = $urandom;
        q = $urandom;
      end
      1: d = int'($urandom_range(0, 400)) - 200;
      2, 3: begin
        d = int'(sb.max_mod) + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1)) d = -d;
      end
      4: d = 0;
      default: d = int'($urandom_range(0, 92680)) - 46340;
    endcase
    return make_req(action_t'($urandom_range(0, 1)), d, q);
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_request(random_request());
  endtask

  task automatic set_max_mod(input logic [MOD_W-1:0] value);
    apb_access(1'b1, ADDR_MAX_MOD, {{(DATA_W-MOD_W){1'b0}}, value});
    apb_access(1'b0, ADDR_MAX_MOD, '0);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    vec_req_t directed[$];

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset value of the register
    apb_access(1'b0, ADDR_MAX_MOD, '0);

    // zero radicand, tiny vectors, field extremes
    directed.push_back(make_req(ACT_MAGNITUDE, 0, 0));
    directed.push_back(make_req(ACT_MAGNITUDE, 1, 0));
    directed.push_back(make_req(ACT_MAGNITUDE, -1, -1));
    directed.push_back(make_req(ACT_MAGNITUDE, 46340, 46340));
    directed.push_back(make_req(ACT_MAGNITUDE, -46340, 0));
    // radicand beyond 32 bits saturates, root beyond 16 bits saturates
    directed.push_back(make_req(ACT_MAGNITUDE, 65535, 65535));
    directed.push_back(make_req(ACT_MAGNITUDE, -65536, -65536));
    directed.push_back(make_req(ACT_MAGNITUDE, -65536, 0));
    directed.push_back(make_req(ACT_MAGNITUDE, 46341, 46341));
    // start-guess thresholds, just below and at or above each
    directed.push_back(make_req(ACT_MAGNITUDE, 99, 14));
    directed.push_back(make_req(ACT_MAGNITUDE, 100, 0));
    directed.push_back(make_req(ACT_MAGNITUDE, 3162, 41));
    directed.push_back(make_req(ACT_MAGNITUDE, 3162, 42));
    directed.push_back(make_req(ACT_MAGNITUDE, 31622, 221));
    directed.push_back(make_req(ACT_MAGNITUDE, 31622, 222));
    // headroom: full budget, exact budget, overdrawn both signs, uq ignored
    directed.push_back(make_req(ACT_HEADROOM, 0, 0));
    directed.push_back(make_req(ACT_HEADROOM, 37837, -65536));
    directed.push_back(make_req(ACT_HEADROOM, -37837, 65535));
    directed.push_back(make_req(ACT_HEADROOM, 37838, 0));
    directed.push_back(make_req(ACT_HEADROOM, -37838, 0));
    directed.push_back(make_req(ACT_HEADROOM, -65536, 0));
    directed.push_back(make_req(ACT_HEADROOM, 65535, 0));
    directed.push_back(make_req(ACT_HEADROOM, 1000, 12345));
    foreach (directed[i]) send_request(directed[i]);

    // random items at reset value; long result hold-off lands here
    send_random(250);
    drain_requests();

    // empty budget
    set_max_mod(16'd0);
    send_random(270);
    drain_requests();

    // widest register value, no idling on either side
    idle_on = 1'b0;
    set_max_mod(16'hFFFF);
    send_random(270);
    drain_requests();
    idle_on = 1'b1;

    set_max_mod(16'd46340);
    send_random(270);
    drain_requests();

    // write to the spare address must leave the register alone
    apb_access(1'b1, ADDR_SPARE, $urandom);
    apb_access(1'b0, ADDR_MAX_MOD, '0);
    set_max_mod(16'($urandom_range(0, 46340)));
    send_random(270);
    drain_requests();

    set_max_mod(16'd1);
    send_random(270);
    drain_requests();

    set_max_mod(MOD_RESET);
    send_random(270);
    drain_requests();

    // catch stray results
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_roots.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
